// ===== sv/ppsc_pkg.sv =====
package ppsc_pkg;

  // Store geometry.
  localparam int STORE_DEPTH = 1024;
  localparam int HALF_DEPTH  = STORE_DEPTH / 2;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Field widths.
  localparam int COUNT_W = 10;
  localparam int ELEM_W  = 9;
  localparam int RAW_W   = 12;
  localparam int MV_W    = 12;
  localparam int CNT_W   = 32;

  // Window arithmetic is carried one bit wider than the widest operand.
  localparam int CALC_W = ((ADDR_W > COUNT_W) ? ADDR_W : COUNT_W) + 1;

  // Millivolt conversion: (raw * 3300 + 2047) / 4095, where 4095 = 2^12 - 1.
  localparam int MV_SCALE  = 3300;
  localparam int MV_ROUND  = 2047;
  localparam int DIV_SHIFT = 12;
  localparam int PROD_W    = 24;
  localparam int SUM_W     = PROD_W + 1;

  // Ready mask bit positions.
  localparam int BIT_FIRST  = 0;
  localparam int BIT_SECOND = 1;

  typedef enum logic [2:0] {
    ACT_SAMPLE      = 3'd0,
    ACT_TAKE        = 3'd1,
    ACT_READ_BLOCK  = 3'd2,
    ACT_READ_LATEST = 3'd3,
    ACT_ERROR       = 3'd4,
    ACT_CLEAR       = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    TAKE_NONE   = 2'd0,
    TAKE_FIRST  = 2'd1,
    TAKE_SECOND = 2'd2
  } taken_t;

endpackage

// ===== sv/ping_pong_sample_capture_core.sv =====
// Ping-pong sample capture core.
// A circular store of 1024 raw 12-bit samples split into two halves. Each
// input transaction carries one action: write a sample, take a ready half,
// read one sample of a half or of the latest stable window, count an error,
// or clear the ready mask and counters.
// Input channel: in_valid/in_stall with action, sample, half_select,
// elem_index and count. Output channel: out_valid/out_stall with millivolts,
// in_range, taken_half, ready_bits, event_total and overrun_total.
// Every input transaction yields exactly one output transaction.
// State, the store read and the first-stage registers update when a
// transaction is accepted; the millivolt conversion (one constant multiply
// and a shift-add divide by 4095) then fills the output register.
// Throughput is one transaction per cycle while the output is not stalled.
// When the receiver stalls a full output register, the whole pipeline holds
// and in_stall rises in the same cycle. Reset clears the write pointer,
// ready mask, counters and both pipeline valid flags; store contents stay
// undefined until written.
module ping_pong_sample_capture_core
  import ppsc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          action,
  input  logic [RAW_W-1:0]    sample,
  input  logic                half_select,
  input  logic [ELEM_W-1:0]   elem_index,
  input  logic [COUNT_W-1:0]  count,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [MV_W-1:0]     millivolts,
  output logic                in_range,
  output logic [1:0]          taken_half,
  output logic [1:0]          ready_bits,
  output logic [CNT_W-1:0]    event_total,
  output logic [CNT_W-1:0]    overrun_total
);

  // Architectural state.
  logic [ADDR_W-1:0] write_pointer, write_pointer_next;
  logic [1:0]        ready_mask, ready_mask_next;
  logic [CNT_W-1:0]  event_counter, event_counter_next;
  logic [CNT_W-1:0]  overrun_counter, overrun_counter_next;

  // Sample store and its registered read port.
  logic [RAW_W-1:0]  sample_store [STORE_DEPTH];
  logic [RAW_W-1:0]  rd_data;

  // First pipeline stage.
  logic              s1_valid;
  logic              s1_in_range;
  taken_t            s1_taken;
  logic [1:0]        s1_ready;
  logic [CNT_W-1:0]  s1_events;
  logic [CNT_W-1:0]  s1_overruns;

  // Step decode.
  logic              advance;
  logic              in_accept;
  action_t           act;
  logic              do_write;
  logic              rd_hit;
  taken_t            taken_next;
  logic [CALC_W-1:0] cnt_ext, half_ext, cnt_clamp, elem_ext;
  logic [CALC_W-1:0] win_start, rd_pos;
  logic [ADDR_W-1:0] rd_addr;
  logic              window_ok;

  // Conversion stage.
  logic [PROD_W-1:0] mv_prod;
  logic [PROD_W-1:0] mv_biased;
  logic [SUM_W-1:0]  mv_sum;
  logic [MV_W-1:0]   mv_conv;

  // The pipeline moves whenever the output register is free or being taken.
  assign advance   = !out_valid || !out_stall;
  assign in_stall  = !advance;
  assign in_accept = in_valid && advance;
  assign act       = action_t'(action);

  // Read window: clamp the count to half depth and place the window.
  always_comb begin
    cnt_ext   = CALC_W'(count);
    half_ext  = CALC_W'(HALF_DEPTH);
    elem_ext  = CALC_W'(elem_index);
    cnt_clamp = (cnt_ext > half_ext) ? half_ext : cnt_ext;
    window_ok = (cnt_clamp != '0) && (elem_ext < cnt_clamp);
    if (act == ACT_READ_BLOCK) begin
      win_start = half_select ? half_ext : '0;
    end else begin
      // The stable half is the one the write pointer is not in.
      win_start = ((CALC_W'(write_pointer) < half_ext) ? half_ext : '0)
                  + half_ext - cnt_clamp;
    end
    rd_pos  = win_start + elem_ext;
    rd_addr = rd_pos[ADDR_W-1:0];
  end

  // State update for one transaction.
  always_comb begin
    write_pointer_next   = write_pointer;
    ready_mask_next      = ready_mask;
    event_counter_next   = event_counter;
    overrun_counter_next = overrun_counter;
    taken_next           = TAKE_NONE;
    do_write             = 1'b0;
    rd_hit               = 1'b0;
    unique case (act) inside
      ACT_SAMPLE: begin
        do_write = 1'b1;
        if (write_pointer == ADDR_W'(STORE_DEPTH - 1)) begin
          // Wrapping completes the second half.
          write_pointer_next = '0;
          if (ready_mask[BIT_SECOND]) begin
            overrun_counter_next = overrun_counter + 1'b1;
          end
          ready_mask_next[BIT_SECOND] = 1'b1;
          event_counter_next = event_counter + 1'b1;
        end else begin
          write_pointer_next = write_pointer + 1'b1;
          if (write_pointer == ADDR_W'(HALF_DEPTH - 1)) begin
            if (ready_mask[BIT_FIRST]) begin
              overrun_counter_next = overrun_counter + 1'b1;
            end
            ready_mask_next[BIT_FIRST] = 1'b1;
            event_counter_next = event_counter + 1'b1;
          end
        end
      end
      ACT_TAKE: begin
        if (ready_mask[BIT_FIRST]) begin
          ready_mask_next[BIT_FIRST] = 1'b0;
          taken_next = TAKE_FIRST;
        end else if (ready_mask[BIT_SECOND]) begin
          ready_mask_next[BIT_SECOND] = 1'b0;
          taken_next = TAKE_SECOND;
        end
      end
      ACT_READ_BLOCK, ACT_READ_LATEST: begin
        rd_hit = window_ok;
      end
      ACT_ERROR: begin
        overrun_counter_next = overrun_counter + 1'b1;
      end
      ACT_CLEAR: begin
        ready_mask_next      = '0;
        event_counter_next   = '0;
        overrun_counter_next = '0;
      end
      default: begin
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer   <= '0;
      ready_mask      <= '0;
      event_counter   <= '0;
      overrun_counter <= '0;
    end else if (in_accept) begin
      write_pointer   <= write_pointer_next;
      ready_mask      <= ready_mask_next;
      event_counter   <= event_counter_next;
      overrun_counter <= overrun_counter_next;
    end
  end

  // Store write and registered read.
  always_ff @(posedge clk) begin
    if (in_accept && do_write) begin
      sample_store[write_pointer] <= sample;
    end
    if (in_accept && rd_hit) begin
      rd_data <= sample_store[rd_addr];
    end
  end

  // First stage: control and status after the step.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_in_range <= rd_hit;
      s1_taken    <= taken_next;
      s1_ready    <= ready_mask_next;
      s1_events   <= event_counter_next;
      s1_overruns <= overrun_counter_next;
    end
  end

  // Millivolts: divide by 2^12 - 1 as (x + (x >> 12) + 1) >> 12.
  always_comb begin
    mv_prod   = PROD_W'(rd_data) * PROD_W'(MV_SCALE);
    mv_biased = mv_prod + PROD_W'(MV_ROUND);
    mv_sum    = SUM_W'(mv_biased) + SUM_W'(mv_biased >> DIV_SHIFT) + SUM_W'(1);
    mv_conv   = mv_sum[DIV_SHIFT +: MV_W];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      millivolts    <= s1_in_range ? mv_conv : '0;
      in_range      <= s1_in_range;
      taken_half    <= s1_taken;
      ready_bits    <= s1_ready;
      event_total   <= s1_events;
      overrun_total <= s1_overruns;
    end
  end

`ifndef SYNTHESIS
  // A nonzero reading only comes from an in-window read.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && millivolts != '0) |-> in_range)
    else $error("millivolts nonzero outside a read window");

  // A transaction is either a take or a read, never both.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(in_range && taken_half != TAKE_NONE))
    else $error("take and read reported together");

  // Converted values never exceed full scale.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (millivolts <= MV_W'(MV_SCALE)))
    else $error("millivolts above full scale");

  // The write pointer stays inside the store.
  assert property (@(posedge clk) disable iff (rst)
    CALC_W'(write_pointer) < CALC_W'(STORE_DEPTH))
    else $error("write pointer out of range");

  // The event counter holds, steps by one or is cleared.
  assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (event_counter == $past(event_counter) ||
              event_counter == $past(event_counter) + 1'b1 ||
              event_counter == '0))
    else $error("event counter jumped");
`endif

endmodule
